// ===== sv/tlbptu_pkg.sv =====
// ----------------------------------------------------------------------------
// tlbptu_pkg
// Shared sizes and types of the TLB and page table translation unit.
// ----------------------------------------------------------------------------
package tlbptu_pkg;

    localparam int ADDR_BITS   = 16;
    localparam int PAGE_BITS   = 8;
    localparam int OFFSET_BITS = 8;
    localparam int TLB_ENTRIES = 16;
    localparam int FRAME_COUNT = 256;
    localparam int FRAME_BITS  = $clog2(FRAME_COUNT);
    localparam int PAGE_COUNT  = 1 << PAGE_BITS;
    localparam int USER_BITS   = 2;

    // tuser bit positions on the result side
    localparam int USER_HIT   = 0;
    localparam int USER_FAULT = 1;

    typedef logic [PAGE_BITS-1:0]   t_page;
    typedef logic [FRAME_BITS-1:0]  t_frame;
    typedef logic [OFFSET_BITS-1:0] t_offset;

    typedef struct packed {
        logic   valid;
        t_page  page;
        t_frame frame;
    } t_tlb_entry;

endpackage

// ===== sv/tlbptu_ram.sv =====
// ----------------------------------------------------------------------------
// tlbptu_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module tlbptu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/tlbptu_cell.sv =====
// ----------------------------------------------------------------------------
// tlbptu_cell
// One TLB entry: holds page, frame and valid, compares against the lookup
// page, and passes its entry to the next cell when the row shifts.
// ----------------------------------------------------------------------------
module tlbptu_cell import tlbptu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift,
    input  t_tlb_entry i_entry,
    input  t_page      i_page,
    output t_tlb_entry o_entry,
    output logic       o_match
);

    t_tlb_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_entry.valid && (r_entry.page == i_page);

endmodule

// ===== sv/tlb_page_table_translation_unit.sv =====
// ----------------------------------------------------------------------------
// tlb_page_table_translation_unit
// Logical to physical address translation through a fully associative TLB
// backed by a demand-paged page table.
// ----------------------------------------------------------------------------
// One logical address per request; one result per request. The request is
// registered when taken and the result when the lookup finishes; a new
// request is taken in that same cycle, so the unit sustains one address
// per cycle while the result side is ready. The page table frame store is
// read at acceptance and its data used in the lookup cycle; the TLB is a row
// of cells that shifts on every miss, so the oldest entry drops off the end.
// Faults get frames in order from zero, saturating at the last frame.
// ----------------------------------------------------------------------------
module tlb_page_table_translation_unit import tlbptu_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [ADDR_BITS-1:0] s_axis_tdata,  // [15:0] logical_address
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [ADDR_BITS-1:0] m_axis_tdata,  // [15:0] physical_address
    output logic [USER_BITS-1:0] m_axis_tuser   // [0] tlb_hit, [1] page_fault
);

    logic                 r_busy;
    t_page                r_page;
    t_offset              r_offset;
    t_frame               r_next_frame;
    logic [PAGE_COUNT-1:0] r_map_valid;
    logic                 r_out_valid;
    logic [ADDR_BITS-1:0] r_out_addr;
    logic                 r_out_hit;
    logic                 r_out_fault;

    logic       w_accept;
    logic       w_finish;
    t_page      w_in_page;
    t_frame     w_map_frame;
    logic       w_hit;
    logic       w_fault;
    t_frame     w_hit_frame;
    t_frame     w_frame;
    t_tlb_entry w_new_entry;
    logic [FRAME_BITS+OFFSET_BITS-1:0] w_pa_full;

    t_tlb_entry               w_cell_entry [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0]   w_match;

    assign w_in_page     = t_page'(s_axis_tdata >> OFFSET_BITS);
    assign w_finish      = r_busy && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_busy || w_finish;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    tlbptu_ram #(
        .WIDTH (FRAME_BITS),
        .DEPTH (PAGE_COUNT)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_finish && w_fault),
        .i_wr_addr (r_page),
        .i_wr_data (r_next_frame),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_in_page),
        .o_rd_data (w_map_frame)
    );

    assign w_new_entry = '{valid: 1'b1, page: r_page, frame: w_frame};

    for (genvar g = 0; g < TLB_ENTRIES; g++) begin : g_cell
        tlbptu_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_finish && !w_hit),
            .i_entry ((g == 0) ? w_new_entry : w_cell_entry[(g == 0) ? 0 : g-1]),
            .i_page  (r_page),
            .o_entry (w_cell_entry[g]),
            .o_match (w_match[g])
        );
    end

    always_comb begin
        w_hit_frame = '0;
        for (int k = 0; k < TLB_ENTRIES; k++) begin
            w_hit_frame = w_hit_frame | (w_match[k] ? w_cell_entry[k].frame : '0);
        end
    end

    assign w_hit     = |w_match;
    assign w_fault   = !w_hit && !r_map_valid[r_page];
    assign w_frame   = w_hit ? w_hit_frame : (w_fault ? r_next_frame : w_map_frame);
    assign w_pa_full = {w_frame, r_offset};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_next_frame <= '0;
            r_map_valid  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_finish) begin
                r_busy <= 1'b0;
            end
            if (w_finish && w_fault) begin
                r_map_valid[r_page] <= 1'b1;
                if (r_next_frame < FRAME_BITS'(FRAME_COUNT - 1)) begin
                    r_next_frame <= r_next_frame + 1'b1;
                end
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_page   <= w_in_page;
            r_offset <= s_axis_tdata[OFFSET_BITS-1:0];
        end
        if (w_finish) begin
            r_out_addr  <= ADDR_BITS'(w_pa_full);
            r_out_hit   <= w_hit;
            r_out_fault <= w_fault;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_addr;
    always_comb begin
        m_axis_tuser             = '0;
        m_axis_tuser[USER_HIT]   = r_out_hit;
        m_axis_tuser[USER_FAULT] = r_out_fault;
    end

    a_match_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> $onehot0(w_match))
        else $error("several TLB cells match one page");

    a_hit_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[USER_HIT] && m_axis_tuser[USER_FAULT]))
        else $error("result flags both hit and fault");

    a_fault_maps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_finish && w_fault) |=> r_map_valid[$past(r_page)])
        else $error("faulted page not marked mapped");

    a_miss_fills_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_finish && !w_hit) |=> (w_cell_entry[0].valid && w_cell_entry[0].page == $past(r_page)))
        else $error("missed page not placed at TLB head");

endmodule
